[rtl/lmbs_pkg.sv]
package lmbs_pkg;

	localparam int BYTE_W  = 8;
	localparam int OP_W    = 2;
	localparam int ENTRY_W = 2;
	localparam int DATA_W  = 64;
	localparam int LEN_W   = 4;

	localparam int NUM_ENTRIES_DEF     = 4;
	localparam int MAX_MATCH_LEN_DEF   = 8;
	localparam int MAX_REPLACE_LEN_DEF = 8;

	typedef enum logic [OP_W-1:0] {
		OP_DATA  = 2'd0,
		OP_FLUSH = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_DROP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               en;
		logic [ENTRY_W-1:0] entry;
		logic [LEN_W-1:0]   match_len;
		logic [LEN_W-1:0]   replace_len;
	} tbl_wr_t;

endpackage

[rtl/lmbs_table.sv]
module lmbs_table #(
	parameter int NUM_ENTRIES     = lmbs_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_MATCH_LEN   = lmbs_pkg::MAX_MATCH_LEN_DEF,
	parameter int MAX_REPLACE_LEN = lmbs_pkg::MAX_REPLACE_LEN_DEF,
	localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
	localparam int RLW = $clog2(MAX_REPLACE_LEN + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lmbs_pkg::tbl_wr_t                      wr,
	input  logic [lmbs_pkg::DATA_W-1:0]            wr_match_bytes,
	input  logic [lmbs_pkg::DATA_W-1:0]            wr_replace_bytes,
	input  logic [IW-1:0]                          rd_idx,
	output logic [MAX_MATCH_LEN*lmbs_pkg::BYTE_W-1:0]   rd_pat,
	output logic [lmbs_pkg::LEN_W-1:0]             rd_plen,
	output logic [MAX_REPLACE_LEN*lmbs_pkg::BYTE_W-1:0] rd_rep,
	output logic [RLW-1:0]                         rd_rlen
);

	localparam int PW = MAX_MATCH_LEN * lmbs_pkg::BYTE_W;
	localparam int RW = MAX_REPLACE_LEN * lmbs_pkg::BYTE_W;

	logic [lmbs_pkg::LEN_W-1:0] plen_q [NUM_ENTRIES];
	logic [PW-1:0]              pat_q  [NUM_ENTRIES];
	logic [RW-1:0]              rep_q  [NUM_ENTRIES];
	logic [RLW-1:0]             rlen_q [NUM_ENTRIES];

	logic          we;
	logic [IW-1:0] widx;
	logic [RLW-1:0] rlen_sat;

	assign we   = wr.en && (32'(wr.entry) < NUM_ENTRIES);
	assign widx = IW'(wr.entry);
	// replacement length saturates on write
	assign rlen_sat = (wr.replace_len > lmbs_pkg::LEN_W'(MAX_REPLACE_LEN)) ?
		RLW'(MAX_REPLACE_LEN) : RLW'(wr.replace_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				plen_q[i] <= '0;
			end
		end else if (we) begin
			plen_q[widx] <= wr.match_len;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			pat_q[widx]  <= wr_match_bytes[PW-1:0];
			rep_q[widx]  <= wr_replace_bytes[RW-1:0];
			rlen_q[widx] <= rlen_sat;
		end
	end

	assign rd_pat  = pat_q[rd_idx];
	assign rd_plen = plen_q[rd_idx];
	assign rd_rep  = rep_q[rd_idx];
	assign rd_rlen = rlen_q[rd_idx];

endmodule

[rtl/lmbs_cmp.sv]
module lmbs_cmp #(
	parameter int MAX_MATCH_LEN = lmbs_pkg::MAX_MATCH_LEN_DEF,
	localparam int CW = $clog2(MAX_MATCH_LEN + 1)
) (
	input  logic [MAX_MATCH_LEN*lmbs_pkg::BYTE_W-1:0] win,
	input  logic [CW-1:0]                             count,
	input  logic [MAX_MATCH_LEN*lmbs_pkg::BYTE_W-1:0] pat,
	input  logic [lmbs_pkg::LEN_W-1:0]                len,
	output logic                                      hit
);

	localparam int B = lmbs_pkg::BYTE_W;

	always_comb begin
		hit = (len != '0) && (len <= lmbs_pkg::LEN_W'(MAX_MATCH_LEN)) &&
			(len <= lmbs_pkg::LEN_W'(count));
		for (int k = 0; k < MAX_MATCH_LEN; k++) begin
			if ((lmbs_pkg::LEN_W'(k) < len) && (win[B*k +: B] != pat[B*k +: B])) begin
				hit = 1'b0;
			end
		end
	end

endmodule

[rtl/longest_match_byte_substitution.sv]
// longest-match byte substitution
// input channel (in_valid / in_stall) carries one request per item: a data
// byte, a flush, or a table entry write. in_stall is low only while the block
// is idle; table writes and data bytes that do not fill the window are handled
// in idle. once the window holds MAX_MATCH_LEN bytes, one decision is made:
// a single compare unit checks one table entry per cycle, then result bytes
// go out one per cycle while the output can take them, then the window shifts.
// a flush repeats the decision until the window is empty; the request then
// closes in a finish step.
// output channel (out_valid / out_stall) carries one byte per transfer; last
// marks the final byte of an input request. the final byte is held back in a
// holding register until it is known to be last. while out_stall is high and
// a byte is waiting, the output register holds and the sequencer waits;
// the next input request may be taken while the final byte still waits at the output.
// reset clears the window, all pattern lengths (entries disabled), the
// sequencer and the output register.
module longest_match_byte_substitution #(
	parameter int NUM_ENTRIES     = lmbs_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_MATCH_LEN   = lmbs_pkg::MAX_MATCH_LEN_DEF,
	parameter int MAX_REPLACE_LEN = lmbs_pkg::MAX_REPLACE_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lmbs_pkg::OP_W-1:0]     operation,
	input  logic [lmbs_pkg::BYTE_W-1:0]   data_byte,
	input  logic [lmbs_pkg::ENTRY_W-1:0]  entry,
	input  logic [lmbs_pkg::DATA_W-1:0]   match_bytes,
	input  logic [lmbs_pkg::LEN_W-1:0]    match_len,
	input  logic [lmbs_pkg::DATA_W-1:0]   replace_bytes,
	input  logic [lmbs_pkg::LEN_W-1:0]    replace_len,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lmbs_pkg::BYTE_W-1:0]   out_byte,
	output logic                          from_replacement,
	output logic                          last
);

	localparam int B   = lmbs_pkg::BYTE_W;
	localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_MATCH_LEN + 1);
	localparam int WIW = (MAX_MATCH_LEN > 1) ? $clog2(MAX_MATCH_LEN) : 1;
	localparam int RLW = $clog2(MAX_REPLACE_LEN + 1);
	localparam int KIW = (MAX_REPLACE_LEN > 1) ? $clog2(MAX_REPLACE_LEN) : 1;

	lmbs_pkg::state_t state_q, state_d;

	logic [B-1:0]               win_q [MAX_MATCH_LEN];
	logic [MAX_MATCH_LEN*B-1:0] win_flat;
	logic [CW-1:0]              wc_q;
	logic [IW-1:0]              idx_q;
	logic [IW-1:0]              best_q;
	logic [lmbs_pkg::LEN_W-1:0] blen_q;
	logic [RLW-1:0]             k_q;
	logic                       flush_q;
	logic                       hvalid_q;
	logic [B-1:0]               hbyte_q;
	logic                       hrepl_q;
	logic                       ovalid_q;
	logic [B-1:0]               obyte_q;
	logic                       orepl_q;
	logic                       olast_q;

	lmbs_pkg::tbl_wr_t            wr;
	logic [IW-1:0]                rd_idx;
	logic [MAX_MATCH_LEN*B-1:0]   rd_pat;
	logic [lmbs_pkg::LEN_W-1:0]   rd_plen;
	logic [MAX_REPLACE_LEN*B-1:0] rd_rep;
	logic [RLW-1:0]               rd_rlen;
	logic                         hit;

	logic            acc_in;
	logic            out_free;
	logic            push;
	logic            finish_move;
	logic [RLW-1:0]  n_emit;
	logic [CW-1:0]   drop;
	logic [KIW-1:0]  k_idx;
	logic [B-1:0]    emit_byte;

	assign acc_in   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;
	assign rd_idx   = (state_q == lmbs_pkg::ST_SCAN) ? idx_q : best_q;
	assign n_emit   = (blen_q != '0) ? rd_rlen : RLW'(1);
	assign drop     = (blen_q != '0) ? CW'(blen_q) : CW'(1);
	assign k_idx    = k_q[KIW-1:0];
	assign emit_byte = (blen_q != '0) ? rd_rep[B*k_idx +: B] : win_q[0];

	assign wr.en          = acc_in && (operation == lmbs_pkg::OP_WRITE);
	assign wr.entry       = entry;
	assign wr.match_len   = match_len;
	assign wr.replace_len = replace_len;

	always_comb begin
		for (int i = 0; i < MAX_MATCH_LEN; i++) begin
			win_flat[B*i +: B] = win_q[i];
		end
	end

	lmbs_table #(
		.NUM_ENTRIES     (NUM_ENTRIES),
		.MAX_MATCH_LEN   (MAX_MATCH_LEN),
		.MAX_REPLACE_LEN (MAX_REPLACE_LEN)
	) u_table (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr               (wr),
		.wr_match_bytes   (match_bytes),
		.wr_replace_bytes (replace_bytes),
		.rd_idx           (rd_idx),
		.rd_pat           (rd_pat),
		.rd_plen          (rd_plen),
		.rd_rep           (rd_rep),
		.rd_rlen          (rd_rlen)
	);

	lmbs_cmp #(
		.MAX_MATCH_LEN (MAX_MATCH_LEN)
	) u_cmp (
		.win   (win_flat),
		.count (wc_q),
		.pat   (rd_pat),
		.len   (rd_plen),
		.hit   (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		push        = 1'b0;
		finish_move = 1'b0;
		case (state_q)
			lmbs_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (operation)
						lmbs_pkg::OP_DATA: begin
							if (wc_q >= CW'(MAX_MATCH_LEN - 1)) begin
								state_d = lmbs_pkg::ST_SCAN;
							end
						end
						lmbs_pkg::OP_FLUSH: begin
							if (wc_q != '0) begin
								state_d = lmbs_pkg::ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			lmbs_pkg::ST_SCAN: begin
				if (idx_q == IW'(NUM_ENTRIES - 1)) begin
					state_d = lmbs_pkg::ST_EMIT;
				end
			end
			lmbs_pkg::ST_EMIT: begin
				if (k_q == n_emit) begin
					state_d = lmbs_pkg::ST_DROP;
				end else if (!hvalid_q || out_free) begin
					push = 1'b1;
				end
			end
			lmbs_pkg::ST_DROP: begin
				state_d = (flush_q && (wc_q != drop)) ? lmbs_pkg::ST_SCAN :
					lmbs_pkg::ST_FINISH;
			end
			lmbs_pkg::ST_FINISH: begin
				if (!hvalid_q) begin
					state_d = lmbs_pkg::ST_IDLE;
				end else if (out_free) begin
					finish_move = 1'b1;
					state_d     = lmbs_pkg::ST_IDLE;
				end
			end
			default: state_d = lmbs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			idx_q    <= '0;
			best_q   <= '0;
			blen_q   <= '0;
			k_q      <= '0;
			flush_q  <= 1'b0;
			hvalid_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (acc_in && (operation == lmbs_pkg::OP_DATA) &&
				(wc_q < CW'(MAX_MATCH_LEN))) begin
				wc_q <= wc_q + CW'(1);
			end
			if (acc_in) begin
				flush_q <= (operation == lmbs_pkg::OP_FLUSH);
			end
			// new decision
			if ((state_d == lmbs_pkg::ST_SCAN) && (state_q != lmbs_pkg::ST_SCAN)) begin
				idx_q  <= '0;
				blen_q <= '0;
				best_q <= '0;
			end
			if (state_q == lmbs_pkg::ST_SCAN) begin
				idx_q <= idx_q + IW'(1);
				k_q   <= '0;
				if (hit && (rd_plen > blen_q)) begin
					best_q <= idx_q;
					blen_q <= rd_plen;
				end
			end
			if (push) begin
				k_q <= k_q + RLW'(1);
			end
			if (state_q == lmbs_pkg::ST_DROP) begin
				wc_q <= wc_q - drop;
			end
			if (push) begin
				hvalid_q <= 1'b1;
			end else if (finish_move) begin
				hvalid_q <= 1'b0;
			end
			if ((push && hvalid_q) || finish_move) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && (operation == lmbs_pkg::OP_DATA) && (wc_q < CW'(MAX_MATCH_LEN))) begin
			win_q[wc_q[WIW-1:0]] <= data_byte;
		end
		if (state_q == lmbs_pkg::ST_DROP) begin
			for (int i = 0; i < MAX_MATCH_LEN; i++) begin
				for (int d = 1; d <= MAX_MATCH_LEN; d++) begin
					if ((drop == CW'(d)) && (i + d < MAX_MATCH_LEN)) begin
						win_q[i] <= win_q[i + d];
					end
				end
			end
		end
		if (push) begin
			hbyte_q <= emit_byte;
			hrepl_q <= (blen_q != '0);
		end
		if ((push && hvalid_q) || finish_move) begin
			obyte_q <= hbyte_q;
			orepl_q <= hrepl_q;
			olast_q <= finish_move;
		end
	end

	assign out_valid        = ovalid_q;
	assign out_byte         = obyte_q;
	assign from_replacement = orepl_q;
	assign last             = olast_q;

	a_wc_range: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= CW'(MAX_MATCH_LEN))
		else $error("window count out of range");

	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmbs_pkg::ST_IDLE |-> !hvalid_q)
		else $error("held byte left behind at idle");

	a_drop_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lmbs_pkg::ST_DROP |-> (wc_q != '0) && (drop <= wc_q))
		else $error("drop exceeds window");

	a_data_one_decision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lmbs_pkg::ST_DROP) && !flush_q |=> state_q == lmbs_pkg::ST_FINISH)
		else $error("data byte made more than one decision");

endmodule
